[src/bsif_pkg.sv]
// Shared types, constants and the 8051 opcode length function for the instruction framer.
package bsif_pkg;

    localparam int unsigned HOLD_DEPTH  = 3;
    localparam int unsigned MAX_RESULTS = 4;

    typedef enum logic [1:0] {
        KIND_ORIGIN = 2'd0,
        KIND_INSTR  = 2'd1,
        KIND_RAW    = 2'd2,
        KIND_END    = 2'd3
    } t_out_kind;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } t_back_state;

    // Classified request as it travels through the queue (address carried apart).
    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
        logic [1:0] width;
    } t_item_tag;

    localparam int unsigned TAG_W = $bits(t_item_tag);

    // Standard 8051 instruction length from the opcode byte; reserved 0xA5 counts as 1.
    function automatic logic [1:0] op_width(input logic [7:0] op);
        logic [3:0] hi;
        logic [3:0] lo;
        logic [1:0] w;
        hi = op[7:4];
        lo = op[3:0];
        w  = 2'd1;
        if (lo == 4'h1) begin
            w = 2'd2;
        end else begin
            unique case (hi)
                4'h0: w = (lo == 4'h2) ? 2'd3 : (lo == 4'h5) ? 2'd2 : 2'd1;
                4'h1: w = (lo == 4'h0 || lo == 4'h2) ? 2'd3 : (lo == 4'h5) ? 2'd2 : 2'd1;
                4'h2, 4'h3:
                    w = (lo == 4'h0) ? 2'd3 : (lo == 4'h4 || lo == 4'h5) ? 2'd2 : 2'd1;
                4'h4, 4'h5, 4'h6:
                    w = (lo == 4'h3) ? 2'd3 : (lo <= 4'h5) ? 2'd2 : 2'd1;
                4'h7: w = (lo == 4'h3) ? 2'd1 : (lo == 4'h5) ? 2'd3 : 2'd2;
                4'h8: w = (lo == 4'h3 || lo == 4'h4) ? 2'd1 : (lo == 4'h5) ? 2'd3 : 2'd2;
                4'h9: w = (lo == 4'h0) ? 2'd3
                        : (lo == 4'h2 || lo == 4'h4 || lo == 4'h5) ? 2'd2 : 2'd1;
                4'hA: w = (lo == 4'h3 || lo == 4'h4 || lo == 4'h5) ? 2'd1 : 2'd2;
                4'hB: w = (lo == 4'h3) ? 2'd1 : (lo >= 4'h4) ? 2'd3 : 2'd2;
                4'hC: w = (lo == 4'h0 || lo == 4'h2 || lo == 4'h5) ? 2'd2 : 2'd1;
                4'hD: w = (lo == 4'h5) ? 2'd3
                        : (lo == 4'h0 || lo == 4'h2 || lo >= 4'h8) ? 2'd2 : 2'd1;
                4'hE, 4'hF: w = (lo == 4'h5) ? 2'd2 : 2'd1;
                default: w = 2'd1;
            endcase
        end
        return w;
    endfunction

endpackage

[src/bsif_front.sv]
// Front end: accepts requests, drops everything after end of stream, tags opcode length.
module bsif_front
    import bsif_pkg::*;
#(
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_kind,
    input  logic [7:0]            i_byte,
    input  logic [ADDR_WIDTH-1:0] i_addr,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output t_item_tag             o_push_tag,
    output logic [ADDR_WIDTH-1:0] o_push_addr
);

    logic r_ended;
    logic n_ended;
    logic accept;

    // once the end mark is in, later requests are swallowed
    assign o_ready = r_ended || !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && !r_ended;

    assign o_push_tag.is_end = i_kind;
    assign o_push_tag.data   = i_byte;
    assign o_push_tag.width  = op_width(i_byte);
    assign o_push_addr       = i_addr;

    assign n_ended = r_ended || (accept && i_kind);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended <= 1'b0;
        end else begin
            r_ended <= n_ended;
        end
    end

endmodule

[src/bsif_queue.sv]
// Small FIFO decoupling the front end from the framing engine.
module bsif_queue #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned W     = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_push_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_pop_valid,
    output logic [W-1:0] o_pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[src/bsif_back.sv]
// Framing engine: holds up to three bytes and produces one result per step.
module bsif_back
    import bsif_pkg::*;
#(
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_item_tag             i_q_tag,
    input  logic [ADDR_WIDTH-1:0] i_q_addr,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_kind             o_kind,
    output logic [ADDR_WIDTH-1:0] o_addr,
    output logic [1:0]            o_width,
    output logic [7:0]            o_first,
    output logic [7:0]            o_second,
    output logic [7:0]            o_third,
    output logic                  o_last
);

    // held bytes
    logic [7:0]            r_held_byte [HOLD_DEPTH];
    logic [1:0]            r_held_wid  [HOLD_DEPTH];
    logic [ADDR_WIDTH-1:0] r_held_addr [HOLD_DEPTH];
    logic [7:0]            n_held_byte [HOLD_DEPTH];
    logic [1:0]            n_held_wid  [HOLD_DEPTH];
    logic [ADDR_WIDTH-1:0] n_held_addr [HOLD_DEPTH];
    logic [1:0]            r_held_cnt, n_held_cnt;

    logic                  r_origin_seen, n_origin_seen;
    logic                  r_stream_ended, n_stream_ended;
    logic                  r_end_sent, n_end_sent;
    logic                  r_raw_run, n_raw_run;
    logic [ADDR_WIDTH-1:0] r_expected, n_expected;
    logic [2:0]            r_n, n_n;
    t_back_state           r_state, n_state;

    // result waiting until we know whether it closes the request
    logic                  r_pend_valid, n_pend_valid;
    t_out_kind             r_pend_kind, n_pend_kind;
    logic [ADDR_WIDTH-1:0] r_pend_addr, n_pend_addr;
    logic [1:0]            r_pend_w, n_pend_w;
    logic [7:0]            r_pend_b0, n_pend_b0;
    logic [7:0]            r_pend_b1, n_pend_b1;
    logic [7:0]            r_pend_b2, n_pend_b2;

    // output register
    logic                  r_out_valid, n_out_valid;
    t_out_kind             r_out_kind, n_out_kind;
    logic [ADDR_WIDTH-1:0] r_out_addr, n_out_addr;
    logic [1:0]            r_out_w, n_out_w;
    logic [7:0]            r_out_b0, n_out_b0;
    logic [7:0]            r_out_b1, n_out_b1;
    logic [7:0]            r_out_b2, n_out_b2;
    logic                  r_out_last, n_out_last;

    // one framing step
    logic [1:0]            run;
    logic                  cont01, cont12;
    logic [1:0]            w0;
    logic                  st_go;
    t_out_kind             st_kind;
    logic [ADDR_WIDTH-1:0] st_addr;
    logic [1:0]            st_w;
    logic [7:0]            st_b0, st_b1, st_b2;
    logic [1:0]            st_drop;
    logic                  st_end, st_org, st_exp_ld, st_raw_ld, st_raw;
    logic [ADDR_WIDTH-1:0] st_exp;
    logic                  can_push;

    assign cont01   = ((r_held_addr[1] - r_held_addr[0]) == ADDR_WIDTH'(1));
    assign cont12   = ((r_held_addr[2] - r_held_addr[1]) == ADDR_WIDTH'(1));
    assign w0       = r_held_wid[0];
    assign can_push = !r_out_valid || i_ready;

    always_comb begin
        if (r_held_cnt == 2'd0) begin
            run = 2'd0;
        end else if (r_held_cnt == 2'd1 || !cont01) begin
            run = 2'd1;
        end else if (r_held_cnt == 2'd2 || !cont12) begin
            run = 2'd2;
        end else begin
            run = 2'd3;
        end
    end

    always_comb begin
        st_go     = 1'b0;
        st_kind   = KIND_ORIGIN;
        st_addr   = r_held_addr[0];
        st_w      = 2'd0;
        st_b0     = 8'd0;
        st_b1     = 8'd0;
        st_b2     = 8'd0;
        st_drop   = 2'd0;
        st_end    = 1'b0;
        st_org    = 1'b0;
        st_exp_ld = 1'b0;
        st_exp    = r_held_addr[0];
        st_raw_ld = 1'b0;
        st_raw    = 1'b0;
        priority if (r_held_cnt == 2'd0 && r_stream_ended) begin
            if (!r_end_sent) begin
                st_go   = 1'b1;
                st_kind = KIND_END;
                st_addr = '0;
                st_end  = 1'b1;
            end
        end else if (run == 2'd0) begin
            st_go = 1'b0;
        end else if (!r_origin_seen || r_held_addr[0] != r_expected) begin
            st_go     = 1'b1;
            st_kind   = KIND_ORIGIN;
            st_org    = 1'b1;
            st_exp_ld = 1'b1;
        end else if (r_raw_run || (run < w0 && (r_held_cnt > run || r_stream_ended))) begin
            // short run: bytes go out one at a time
            st_go     = 1'b1;
            st_kind   = KIND_RAW;
            st_w      = 2'd1;
            st_b0     = r_held_byte[0];
            st_drop   = 2'd1;
            st_exp_ld = 1'b1;
            st_exp    = r_held_addr[0] + ADDR_WIDTH'(1);
            st_raw_ld = 1'b1;
            st_raw    = (run > 2'd1);
        end else if (run == w0) begin
            st_go     = 1'b1;
            st_kind   = KIND_INSTR;
            st_w      = w0;
            st_b0     = r_held_byte[0];
            st_b1     = (w0 > 2'd1) ? r_held_byte[1] : 8'd0;
            st_b2     = (w0 > 2'd2) ? r_held_byte[2] : 8'd0;
            st_drop   = w0;
            st_exp_ld = 1'b1;
            st_exp    = r_held_addr[0] + ADDR_WIDTH'(w0);
        end else begin
            st_go = 1'b0;
        end
    end

    always_comb begin
        n_held_byte    = r_held_byte;
        n_held_wid     = r_held_wid;
        n_held_addr    = r_held_addr;
        n_held_cnt     = r_held_cnt;
        n_origin_seen  = r_origin_seen;
        n_stream_ended = r_stream_ended;
        n_end_sent     = r_end_sent;
        n_raw_run      = r_raw_run;
        n_expected     = r_expected;
        n_n            = r_n;
        n_state        = r_state;
        n_pend_valid   = r_pend_valid;
        n_pend_kind    = r_pend_kind;
        n_pend_addr    = r_pend_addr;
        n_pend_w       = r_pend_w;
        n_pend_b0      = r_pend_b0;
        n_pend_b1      = r_pend_b1;
        n_pend_b2      = r_pend_b2;
        n_out_valid    = r_out_valid && !i_ready;
        n_out_kind     = r_out_kind;
        n_out_addr     = r_out_addr;
        n_out_w        = r_out_w;
        n_out_b0       = r_out_b0;
        n_out_b1       = r_out_b1;
        n_out_b2       = r_out_b2;
        n_out_last     = r_out_last;
        o_q_pop        = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_n     = 3'd0;
                    n_state = BK_RUN;
                    if (i_q_tag.is_end) begin
                        n_stream_ended = 1'b1;
                    end else if (r_held_cnt < 2'(HOLD_DEPTH)) begin
                        n_held_byte[r_held_cnt] = i_q_tag.data;
                        n_held_wid[r_held_cnt]  = i_q_tag.width;
                        n_held_addr[r_held_cnt] = i_q_addr;
                        n_held_cnt              = r_held_cnt + 2'd1;
                    end
                end
            end
            BK_RUN: begin
                if (st_go && r_n != 3'(MAX_RESULTS)) begin
                    if (!r_pend_valid || can_push) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = r_pend_kind;
                            n_out_addr  = r_pend_addr;
                            n_out_w     = r_pend_w;
                            n_out_b0    = r_pend_b0;
                            n_out_b1    = r_pend_b1;
                            n_out_b2    = r_pend_b2;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_kind  = st_kind;
                        n_pend_addr  = st_addr;
                        n_pend_w     = st_w;
                        n_pend_b0    = st_b0;
                        n_pend_b1    = st_b1;
                        n_pend_b2    = st_b2;
                        n_n          = r_n + 3'd1;
                        if (st_end) begin
                            n_end_sent = 1'b1;
                        end
                        if (st_org) begin
                            n_origin_seen = 1'b1;
                        end
                        if (st_exp_ld) begin
                            n_expected = st_exp;
                        end
                        if (st_raw_ld) begin
                            n_raw_run = st_raw;
                        end
                        unique case (st_drop)
                            2'd0: begin
                            end
                            2'd1: begin
                                n_held_byte[0] = r_held_byte[1];
                                n_held_wid[0]  = r_held_wid[1];
                                n_held_addr[0] = r_held_addr[1];
                                n_held_byte[1] = r_held_byte[2];
                                n_held_wid[1]  = r_held_wid[2];
                                n_held_addr[1] = r_held_addr[2];
                            end
                            2'd2: begin
                                n_held_byte[0] = r_held_byte[2];
                                n_held_wid[0]  = r_held_wid[2];
                                n_held_addr[0] = r_held_addr[2];
                            end
                            default: begin
                            end
                        endcase
                        n_held_cnt = r_held_cnt - st_drop;
                    end
                end else if (r_pend_valid) begin
                    if (can_push) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = r_pend_kind;
                        n_out_addr   = r_pend_addr;
                        n_out_w      = r_pend_w;
                        n_out_b0     = r_pend_b0;
                        n_out_b1     = r_pend_b1;
                        n_out_b2     = r_pend_b2;
                        n_out_last   = 1'b1;
                        n_pend_valid = 1'b0;
                        n_state      = BK_IDLE;
                    end
                end else begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt     <= 2'd0;
            r_origin_seen  <= 1'b0;
            r_stream_ended <= 1'b0;
            r_end_sent     <= 1'b0;
            r_raw_run      <= 1'b0;
            r_expected     <= '0;
            r_n            <= 3'd0;
            r_state        <= BK_IDLE;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_held_cnt     <= n_held_cnt;
            r_origin_seen  <= n_origin_seen;
            r_stream_ended <= n_stream_ended;
            r_end_sent     <= n_end_sent;
            r_raw_run      <= n_raw_run;
            r_expected     <= n_expected;
            r_n            <= n_n;
            r_state        <= n_state;
            r_pend_valid   <= n_pend_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_byte <= n_held_byte;
        r_held_wid  <= n_held_wid;
        r_held_addr <= n_held_addr;
        r_pend_kind <= n_pend_kind;
        r_pend_addr <= n_pend_addr;
        r_pend_w    <= n_pend_w;
        r_pend_b0   <= n_pend_b0;
        r_pend_b1   <= n_pend_b1;
        r_pend_b2   <= n_pend_b2;
        r_out_kind  <= n_out_kind;
        r_out_addr  <= n_out_addr;
        r_out_w     <= n_out_w;
        r_out_b0    <= n_out_b0;
        r_out_b1    <= n_out_b1;
        r_out_b2    <= n_out_b2;
        r_out_last  <= n_out_last;
    end

    assign o_valid  = r_out_valid;
    assign o_kind   = r_out_kind;
    assign o_addr   = r_out_addr;
    assign o_width  = r_out_w;
    assign o_first  = r_out_b0;
    assign o_second = r_out_b1;
    assign o_third  = r_out_b2;
    assign o_last   = r_out_last;

endmodule

[src/byte_stream_instruction_framer_core.sv]
// Top level of the 8051 byte stream instruction framer.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_kind, i_in_byte, i_in_address
//  out     | output    | o_out_valid/i_out_ready | o_out_kind, o_out_address, o_out_width,
//          |           |                         | o_out_first/second/third, o_out_last
//
// Sequence: the framing engine takes a request from the queue, produces its results
//   one step at a time, then closes the request by passing on the last result with
//   o_out_last set. The engine has a single step unit.
// Reset: synchronous, active low; clears queue, held-byte count and all flags.
// Stalls: the front end keeps accepting into a QUEUE_DEPTH queue while the engine
//   works or waits on a full output register; o_in_ready drops only when the queue
//   is full. After end of stream every request is accepted and discarded.
module byte_stream_instruction_framer_core
    import bsif_pkg::*;
#(
    parameter int unsigned ADDR_WIDTH  = 32,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_in_kind,
    input  logic [7:0]  i_in_byte,
    input  logic [31:0] i_in_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_out_kind,
    output logic [31:0] o_out_address,
    output logic [1:0]  o_out_width,
    output logic [7:0]  o_out_first,
    output logic [7:0]  o_out_second,
    output logic [7:0]  o_out_third,
    output logic        o_out_last
);

    localparam int unsigned ENTRY_W = TAG_W + ADDR_WIDTH;

    logic                  queue_full;
    logic                  push;
    t_item_tag             push_tag;
    logic [ADDR_WIDTH-1:0] push_addr;
    logic                  pop;
    logic                  pop_valid;
    logic [ENTRY_W-1:0]    pop_data;
    t_item_tag             pop_tag;
    logic [ADDR_WIDTH-1:0] pop_addr;
    t_out_kind             out_kind;
    logic [ADDR_WIDTH-1:0] out_addr;

    // addresses are taken modulo 2^ADDR_WIDTH from here on
    bsif_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_kind       (i_in_kind),
        .i_byte       (i_in_byte),
        .i_addr       (i_in_address[ADDR_WIDTH-1:0]),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_tag   (push_tag),
        .o_push_addr  (push_addr)
    );

    bsif_queue #(
        .DEPTH (QUEUE_DEPTH),
        .W     (ENTRY_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_tag, push_addr}),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_pop_valid (pop_valid),
        .o_pop_data  (pop_data)
    );

    assign pop_tag  = pop_data[ENTRY_W-1:ADDR_WIDTH];
    assign pop_addr = pop_data[ADDR_WIDTH-1:0];

    bsif_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (pop_valid),
        .i_q_tag   (pop_tag),
        .i_q_addr  (pop_addr),
        .o_q_pop   (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_kind    (out_kind),
        .o_addr    (out_addr),
        .o_width   (o_out_width),
        .o_first   (o_out_first),
        .o_second  (o_out_second),
        .o_third   (o_out_third),
        .o_last    (o_out_last)
    );

    assign o_out_kind    = out_kind;
    assign o_out_address = 32'(out_addr);

endmodule

[src/bsif_checker.sv]
// Port-level checks for the instruction framer, bound to the top level.
module bsif_checker
    import bsif_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_out_kind,
    input logic [31:0] o_out_address,
    input logic [1:0]  o_out_width,
    input logic [7:0]  o_out_first,
    input logic [7:0]  o_out_second,
    input logic [7:0]  o_out_third,
    input logic        o_out_last
);

    // stalled result holds its kind, address, first byte and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_kind)
            && $stable(o_out_address) && $stable(o_out_first) && $stable(o_out_last))
        else $error("stalled result changed");

    // end record is empty and always closes its request
    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_END |-> o_out_last && o_out_width == 2'd0
            && o_out_address == 32'd0 && o_out_first == 8'd0)
        else $error("malformed end record");

    // raw bytes carry one byte, instructions at least one
    a_raw_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_RAW |-> o_out_width == 2'd1
            && o_out_second == 8'd0 && o_out_third == 8'd0)
        else $error("malformed raw byte");

    a_instr_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_INSTR |-> o_out_width != 2'd0
            && (o_out_width == 2'd3 || o_out_third == 8'd0))
        else $error("malformed instruction");

    a_origin_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_ORIGIN |-> o_out_width == 2'd0
            && o_out_first == 8'd0 && o_out_second == 8'd0 && o_out_third == 8'd0)
        else $error("malformed origin record");

endmodule

bind byte_stream_instruction_framer_core bsif_checker u_bsif_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_kind    (o_out_kind),
    .o_out_address (o_out_address),
    .o_out_width   (o_out_width),
    .o_out_first   (o_out_first),
    .o_out_second  (o_out_second),
    .o_out_third   (o_out_third),
    .o_out_last    (o_out_last)
);
